>>> rtl/aase_pkg.sv
// Package for the execute stage: payload structs, opcode, condition and shift codes.
// Used by the interfaces, the shifter, the ALU and the top level; depends on nothing.
package aase_pkg;

    localparam int unsigned DATA_W = 32;

    // Bit positions of the packed NZCV flags
    localparam int unsigned FLAG_N = 3;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_C = 1;
    localparam int unsigned FLAG_V = 0;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } t_alu_op;

    typedef enum logic [3:0] {
        CC_EQ = 4'd0,
        CC_NE = 4'd1,
        CC_CS = 4'd2,
        CC_CC = 4'd3,
        CC_MI = 4'd4,
        CC_PL = 4'd5,
        CC_VS = 4'd6,
        CC_VC = 4'd7,
        CC_HI = 4'd8,
        CC_LS = 4'd9,
        CC_GE = 4'd10,
        CC_LT = 4'd11,
        CC_GT = 4'd12,
        CC_LE = 4'd13,
        CC_AL = 4'd14,
        CC_NV = 4'd15
    } t_cond;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift;

    typedef struct packed {
        logic [3:0]        cmd;
        logic [3:0]        cond_code;
        logic              set_flags;
        logic [3:0]        flags_in;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_m;
        logic              imm_form;
        logic [3:0]        rotate;
        logic [1:0]        shift_type;
        logic              shift_by_register;
        logic [7:0]        shift_amount;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              carry;
    } t_shift_out;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              write_result;
        logic              cond_passed;
        logic [3:0]        flags_out;
    } t_out_item;

endpackage

>>> rtl/aase_ifs.sv
// Handshake interfaces for the instruction channel and the result channel.
// Depends on aase_pkg for the data width.
interface aase_in_if;
    logic                           valid;
    logic                           ready;
    logic [3:0]                     cmd;
    logic [3:0]                     cond_code;
    logic                           set_flags;
    logic [3:0]                     flags_in;
    logic [aase_pkg::DATA_W-1:0]    operand_a;
    logic [aase_pkg::DATA_W-1:0]    operand_m;
    logic                           imm_form;
    logic [3:0]                     rotate;
    logic [1:0]                     shift_type;
    logic                           shift_by_register;
    logic [7:0]                     shift_amount;

    modport source (
        output valid, cmd, cond_code, set_flags, flags_in, operand_a, operand_m,
               imm_form, rotate, shift_type, shift_by_register, shift_amount,
        input  ready
    );
    modport sink (
        input  valid, cmd, cond_code, set_flags, flags_in, operand_a, operand_m,
               imm_form, rotate, shift_type, shift_by_register, shift_amount,
        output ready
    );
endinterface

interface aase_out_if;
    logic                           valid;
    logic                           ready;
    logic [aase_pkg::DATA_W-1:0]    result;
    logic                           write_result;
    logic                           cond_passed;
    logic [3:0]                     flags_out;

    modport source (
        output valid, result, write_result, cond_passed, flags_out,
        input  ready
    );
    modport sink (
        input  valid, result, write_result, cond_passed, flags_out,
        output ready
    );
endinterface

>>> rtl/aase_shifter.sv
// Barrel shifter for the second operand: rotated immediate, shift by immediate
// or by register, with all zero and large-amount cases. Depends on aase_pkg.
module aase_shifter (
    input  aase_pkg::t_in_item   i_item,
    output aase_pkg::t_shift_out o_shift
);

    logic [31:0] m;
    logic        cin;
    logic [4:0]  n5;
    logic [32:0] lsl_w;
    logic [32:0] lsr_w;
    logic [32:0] asr_w;
    logic [63:0] ror_w;
    logic [31:0] fill;
    logic [31:0] imm8;
    logic [4:0]  r2;
    logic [63:0] imm_w;
    logic        amt_zero;
    logic        amt_eq32;
    logic        amt_ge32;

    assign m     = i_item.operand_m;
    assign cin   = i_item.flags_in[aase_pkg::FLAG_C];
    assign n5    = i_item.shift_amount[4:0];
    // Carry lands in the extra bit of the widened LSL, LSR and ASR shifts
    assign lsl_w = {1'b0, m} << n5;
    assign lsr_w = {m, 1'b0} >> n5;
    assign asr_w = 33'($signed({m, 1'b0}) >>> n5);
    assign ror_w = {m, m} >> n5;
    assign fill  = {32{m[31]}};
    assign imm8  = {24'd0, m[7:0]};
    assign r2    = {i_item.rotate, 1'b0};
    assign imm_w = {imm8, imm8} >> r2;

    assign amt_zero = (i_item.shift_amount == 8'd0);
    assign amt_eq32 = (i_item.shift_amount == 8'd32);
    assign amt_ge32 = (i_item.shift_amount[7:5] != 3'd0);

    always_comb begin
        o_shift = '0;
        if (i_item.imm_form) begin
            o_shift.value = imm_w[31:0];
            o_shift.carry = (r2 != 5'd0) ? imm_w[31] : cin;
        end else if (i_item.shift_by_register) begin
            if (amt_zero) begin
                o_shift.value = m;
                o_shift.carry = cin;
            end else begin
                case (aase_pkg::t_shift'(i_item.shift_type))
                    aase_pkg::SH_LSL: begin
                        if (!amt_ge32) begin
                            o_shift.value = lsl_w[31:0];
                            o_shift.carry = lsl_w[32];
                        end else begin
                            o_shift.value = '0;
                            o_shift.carry = amt_eq32 ? m[0] : 1'b0;
                        end
                    end
                    aase_pkg::SH_LSR: begin
                        if (!amt_ge32) begin
                            o_shift.value = lsr_w[32:1];
                            o_shift.carry = lsr_w[0];
                        end else begin
                            o_shift.value = '0;
                            o_shift.carry = amt_eq32 ? m[31] : 1'b0;
                        end
                    end
                    aase_pkg::SH_ASR: begin
                        if (!amt_ge32) begin
                            o_shift.value = asr_w[32:1];
                            o_shift.carry = asr_w[0];
                        end else begin
                            o_shift.value = fill;
                            o_shift.carry = m[31];
                        end
                    end
                    default: begin
                        // Rotate by a multiple of 32 leaves the value, carry is bit 31
                        o_shift.value = ror_w[31:0];
                        o_shift.carry = (n5 == 5'd0) ? m[31] : ror_w[31];
                    end
                endcase
            end
        end else begin
            case (aase_pkg::t_shift'(i_item.shift_type))
                aase_pkg::SH_LSL: begin
                    o_shift.value = lsl_w[31:0];
                    o_shift.carry = (n5 == 5'd0) ? cin : lsl_w[32];
                end
                aase_pkg::SH_LSR: begin
                    // Amount zero encodes a shift by 32
                    o_shift.value = (n5 == 5'd0) ? 32'd0 : lsr_w[32:1];
                    o_shift.carry = (n5 == 5'd0) ? m[31] : lsr_w[0];
                end
                aase_pkg::SH_ASR: begin
                    o_shift.value = (n5 == 5'd0) ? fill : asr_w[32:1];
                    o_shift.carry = (n5 == 5'd0) ? m[31] : asr_w[0];
                end
                default: begin
                    // Amount zero is rotate right extended through carry
                    o_shift.value = (n5 == 5'd0) ? {cin, m[31:1]} : ror_w[31:0];
                    o_shift.carry = (n5 == 5'd0) ? m[0] : ror_w[31];
                end
            endcase
        end
    end

endmodule

>>> rtl/aase_alu.sv
// Condition check, sixteen-operation ALU and NZCV update for one instruction.
// Depends on aase_pkg; takes the shifted operand from aase_shifter.
module aase_alu (
    input  aase_pkg::t_in_item   i_item,
    input  aase_pkg::t_shift_out i_shift,
    output aase_pkg::t_out_item  o_result
);

    logic        fn;
    logic        fz;
    logic        fc;
    logic        fv;
    logic        pass;
    logic        is_test;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] add_x;
    logic [31:0] add_y;
    logic        add_cin;
    logic [32:0] sum;
    logic        add_v;
    logic        arith;
    logic [31:0] res;
    logic        c_new;
    logic        v_new;

    assign fn = i_item.flags_in[aase_pkg::FLAG_N];
    assign fz = i_item.flags_in[aase_pkg::FLAG_Z];
    assign fc = i_item.flags_in[aase_pkg::FLAG_C];
    assign fv = i_item.flags_in[aase_pkg::FLAG_V];
    assign a  = i_item.operand_a;
    assign b  = i_shift.value;

    always_comb begin
        unique case (aase_pkg::t_cond'(i_item.cond_code))
            aase_pkg::CC_EQ: pass = fz;
            aase_pkg::CC_NE: pass = !fz;
            aase_pkg::CC_CS: pass = fc;
            aase_pkg::CC_CC: pass = !fc;
            aase_pkg::CC_MI: pass = fn;
            aase_pkg::CC_PL: pass = !fn;
            aase_pkg::CC_VS: pass = fv;
            aase_pkg::CC_VC: pass = !fv;
            aase_pkg::CC_HI: pass = fc && !fz;
            aase_pkg::CC_LS: pass = !fc || fz;
            aase_pkg::CC_GE: pass = (fn == fv);
            aase_pkg::CC_LT: pass = (fn != fv);
            aase_pkg::CC_GT: pass = !fz && (fn == fv);
            aase_pkg::CC_LE: pass = fz || (fn != fv);
            aase_pkg::CC_AL: pass = 1'b1;
            default:         pass = 1'b0;
        endcase
    end

    // Select adder operands and carry in
    always_comb begin
        add_x   = a;
        add_y   = ~b;
        add_cin = 1'b1;
        arith   = 1'b1;
        unique case (aase_pkg::t_alu_op'(i_item.cmd)) inside
            aase_pkg::OP_SUB, aase_pkg::OP_CMP: begin
                add_x = a; add_y = ~b; add_cin = 1'b1;
            end
            aase_pkg::OP_RSB: begin
                add_x = b; add_y = ~a; add_cin = 1'b1;
            end
            aase_pkg::OP_ADD, aase_pkg::OP_CMN: begin
                add_x = a; add_y = b; add_cin = 1'b0;
            end
            aase_pkg::OP_ADC: begin
                add_x = a; add_y = b; add_cin = fc;
            end
            aase_pkg::OP_SBC: begin
                add_x = a; add_y = ~b; add_cin = fc;
            end
            aase_pkg::OP_RSC: begin
                add_x = b; add_y = ~a; add_cin = fc;
            end
            default: arith = 1'b0;
        endcase
    end

    assign sum   = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
    assign add_v = (~(add_x[31] ^ add_y[31])) & (add_x[31] ^ sum[31]);

    always_comb begin
        unique case (aase_pkg::t_alu_op'(i_item.cmd)) inside
            aase_pkg::OP_AND, aase_pkg::OP_TST: res = a & b;
            aase_pkg::OP_EOR, aase_pkg::OP_TEQ: res = a ^ b;
            aase_pkg::OP_ORR:                   res = a | b;
            aase_pkg::OP_MOV:                   res = b;
            aase_pkg::OP_BIC:                   res = a & ~b;
            aase_pkg::OP_MVN:                   res = ~b;
            default:                            res = sum[31:0];
        endcase
    end

    // Logical ops take carry from the shifter and keep overflow
    assign c_new   = arith ? sum[32] : i_shift.carry;
    assign v_new   = arith ? add_v : fv;
    assign is_test = (i_item.cmd[3:2] == 2'b10);

    always_comb begin
        o_result.result       = res;
        o_result.cond_passed  = pass;
        o_result.write_result = pass && !is_test;
        if (i_item.set_flags && pass) begin
            o_result.flags_out = {res[31], (res == 32'd0), c_new, v_new};
        end else begin
            o_result.flags_out = i_item.flags_in;
        end
    end

endmodule

>>> rtl/arm_alu_shifter_execute.sv
// Execute stage top level: input register, shifter and ALU, result register.
// Depends on aase_pkg, aase_ifs, aase_shifter and aase_alu.
//
// Usage:
//   i_in carries one data-processing instruction per transaction: opcode,
//   condition, S bit, incoming NZCV, both operands and the operand-2 form.
//   o_out carries one result per transaction: ALU value, write enable,
//   condition-pass bit and the new NZCV. Results leave in input order.
// Path: an accepted instruction is held in the input register, goes through
//   the shifter and ALU combinationally, and its result is loaded into the
//   result register, from which o_out presents it.
// Throughput: one instruction per cycle while o_out.ready stays high, set
//   by the single shifter/ALU pass between the input and result registers.
// Reset: i_rst_n low at a clock edge empties both stages; no result is
//   shown and i_in.ready rises once reset is released.
// Stall: when o_out.ready is low with a result waiting, the result register
//   holds; the input register can still take one more transaction, then
//   i_in.ready drops until the result is taken.
module arm_alu_shifter_execute (
    input  logic             i_clk,
    input  logic             i_rst_n,
    aase_in_if.sink          i_in,
    aase_out_if.source       o_out
);

    aase_pkg::t_in_item   in_item;
    aase_pkg::t_shift_out shift_out;
    aase_pkg::t_out_item  alu_out;

    logic                 r_in_valid;
    logic                 n_in_valid;
    aase_pkg::t_in_item   r_in;
    logic                 r_out_valid;
    logic                 n_out_valid;
    aase_pkg::t_out_item  r_out;
    logic                 advance;
    logic                 in_fire;

    // Pack the incoming transaction
    always_comb begin
        in_item.cmd               = i_in.cmd;
        in_item.cond_code         = i_in.cond_code;
        in_item.set_flags         = i_in.set_flags;
        in_item.flags_in          = i_in.flags_in;
        in_item.operand_a         = i_in.operand_a;
        in_item.operand_m         = i_in.operand_m;
        in_item.imm_form          = i_in.imm_form;
        in_item.rotate            = i_in.rotate;
        in_item.shift_type        = i_in.shift_type;
        in_item.shift_by_register = i_in.shift_by_register;
        in_item.shift_amount      = i_in.shift_amount;
    end

    // Advance when the result register is free or being drained
    assign advance    = !r_out_valid || o_out.ready;
    // Hold ready low while in reset
    assign i_in.ready = i_rst_n && (!r_in_valid || advance);
    assign in_fire    = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = r_in_valid;
        end
        if (i_in.ready) begin
            n_in_valid = i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= in_item;
        end
        if (advance && r_in_valid) begin
            r_out <= alu_out;
        end
    end

    aase_shifter u_shifter (
        .i_item  (r_in),
        .o_shift (shift_out)
    );

    aase_alu u_alu (
        .i_item   (r_in),
        .i_shift  (shift_out),
        .o_result (alu_out)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.result       = r_out.result;
    assign o_out.write_result = r_out.write_result;
    assign o_out.cond_passed  = r_out.cond_passed;
    assign o_out.flags_out    = r_out.flags_out;

endmodule
